@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the allocator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define SCP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("allocator assertion failed");

// Checked at every rising edge, reset included.
`define SCP_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("allocator assertion failed");

`endif

@@ hw/rtl/scp_pkg.sv @@
// Constants, types and status codes of the size class pool allocator.
// Depends on nothing; used by the interfaces, the front and back ends, the top and the testbench.
package scp_pkg;

	localparam int CHUNK_BLOCKS = 1024;
	localparam int CLASS_COUNT  = 16;
	localparam int BLOCK_BYTES  = 32;
	localparam int CHUNK_COUNT  = 16;

	localparam int ARENA_BLOCKS = CHUNK_COUNT * CHUNK_BLOCKS;
	localparam int MAX_BYTES    = CLASS_COUNT * BLOCK_BYTES;

	localparam int BYTES_W     = 16;
	localparam int ADDR_W      = 14;
	localparam int LINK_W      = ADDR_W + 1;
	localparam int CLASS_W     = $clog2(CLASS_COUNT);
	localparam int BLKS_W      = CLASS_W + 1;
	localparam int REM_W       = $clog2(CHUNK_BLOCKS + 1);
	localparam int CHUNKS_W    = $clog2(CHUNK_COUNT + 1);
	localparam int CHUNK_SHIFT = $clog2(CHUNK_BLOCKS);
	localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
	localparam int STATUS_W    = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_TOO_LARGE = 2'd1,
		ST_OOM       = 2'd2
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef struct packed {
		op_t                op;
		logic               too_large;
		logic [CLASS_W-1:0] cls;
		logic [ADDR_W-1:0]  freed;
	} req_t;

	typedef struct packed {
		logic valid;
		req_t item;
	} q_head_t;

endpackage

@@ hw/rtl/scp_req_if.sv @@
// Request channel of the allocator: valid, ready and the request word.
// Depends on scp_pkg for the field widths.
interface scp_req_if;
	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic [scp_pkg::BYTES_W-1:0]   request_bytes;
	logic [scp_pkg::ADDR_W-1:0]    freed_block;

	modport source (output valid, operation, request_bytes, freed_block, input ready);
	modport sink (input valid, operation, request_bytes, freed_block, output ready);
endinterface

@@ hw/rtl/scp_rsp_if.sv @@
// Result channel of the allocator: valid, ready and the result word.
// Depends on scp_pkg for the field widths.
interface scp_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [scp_pkg::ADDR_W-1:0]    block_address;
	logic [scp_pkg::STATUS_W-1:0]  status;

	modport source (output valid, block_address, status, input ready);
	modport sink (input valid, block_address, status, output ready);
endinterface

@@ hw/rtl/scp_ram.sv @@
// Generic single port RAM with registered read data.
// Depends on nothing; holds the free list link memory.
module scp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end
endmodule

@@ hw/rtl/scp_front.sv @@
// Front end: accepts request words, sorts them into size classes and holds them
// in a two entry queue for the back end. Depends on scp_pkg and scp_req_if.
module scp_front (
	input  logic              clk,
	input  logic              arst_n,
	scp_req_if.sink           req,
	output scp_pkg::q_head_t  head,
	input  logic              pop
);
	import scp_pkg::*;

	logic [1:0] count_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	req_t       entry_q [2];
	req_t       classed;
	logic       push;
	logic [BYTES_W:0] blks_raw;

	always_comb begin
		blks_raw = ({1'b0, req.request_bytes} + (BYTES_W+1)'(BLOCK_BYTES - 1)) >> BLOCK_SHIFT;
		classed.op = op_t'(req.operation);
		classed.too_large = {1'b0, req.request_bytes} > (BYTES_W+1)'(MAX_BYTES);
		classed.cls = (blks_raw == '0) ? '0 : CLASS_W'(blks_raw - 1'b1);
		classed.freed = req.freed_block;
	end

	assign req.ready = (count_q != 2'd2);
	assign push = req.valid && req.ready;
	assign head.valid = (count_q != 2'd0);
	assign head.item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= classed;
		end
	end
endmodule

@@ hw/rtl/scp_back.sv @@
// Back end: carries out allocate and free words against the list heads, the
// carve pointer and the link memory. Depends on scp_pkg, scp_rsp_if and scp_ram.
`include "assert_macros.svh"

module scp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  scp_pkg::q_head_t  head,
	output logic              pop,
	scp_rsp_if.source         rsp
);
	import scp_pkg::*;

	typedef enum logic [1:0] {
		S_EXEC,
		S_LINK,
		S_SPILL
	} state_t;

	state_t              state_q;
	logic [LINK_W-1:0]   heads_q [CLASS_COUNT];
	logic [ADDR_W-1:0]   ptr_q;
	logic [REM_W-1:0]    rem_q;
	logic [CHUNKS_W-1:0] chunks_q;
	logic [CLASS_W-1:0]  link_cls_q;
	logic                out_valid_q;
	logic [ADDR_W-1:0]   out_addr_q;
	status_t             out_status_q;

	req_t                item;
	logic                go;
	logic [CLASS_W-1:0]  head_idx;
	logic [LINK_W-1:0]   head_val;
	logic [BLKS_W-1:0]   blks;
	logic                need_chunk;
	logic                oom;
	logic                ram_we;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_addr;
	logic [LINK_W-1:0]   ram_wdata;
	logic [LINK_W-1:0]   ram_rdata;
	logic [ADDR_W-1:0]   pop_addr;
	logic [REM_W-1:0]    rem_less;

	assign item = head.item;
	assign go = (state_q == S_EXEC) && head.valid && (!out_valid_q || rsp.ready);
	assign rem_less = rem_q - 1'b1;
	assign head_idx = (state_q == S_SPILL) ? CLASS_W'(rem_less) : item.cls;
	assign head_val = heads_q[head_idx];
	assign blks = {1'b0, item.cls} + 1'b1;
	assign need_chunk = REM_W'(blks) > rem_q;
	assign oom = need_chunk && (chunks_q >= CHUNKS_W'(CHUNK_COUNT));
	assign pop_addr = ADDR_W'(head_val - 1'b1);

	always_comb begin
		ram_we = 1'b0;
		ram_re = 1'b0;
		ram_addr = item.freed;
		ram_wdata = head_val;
		pop = 1'b0;
		if (go) begin
			if (item.too_large) begin
				pop = 1'b1;
			end else if (item.op == OP_FREE) begin
				ram_we = 1'b1;
				pop = 1'b1;
			end else if (head_val != '0) begin
				ram_re = 1'b1;
				ram_addr = pop_addr;
				pop = 1'b1;
			end else begin
				pop = oom || !need_chunk;
			end
		end else if (state_q == S_SPILL && rem_q != '0) begin
			ram_we = 1'b1;
			ram_addr = ptr_q;
		end
	end

	scp_ram #(
		.WIDTH (LINK_W),
		.DEPTH (ARENA_BLOCKS)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_EXEC;
			for (int i = 0; i < CLASS_COUNT; i++) begin
				heads_q[i] <= '0;
			end
			ptr_q <= '0;
			rem_q <= '0;
			chunks_q <= '0;
			link_cls_q <= '0;
			out_valid_q <= 1'b0;
			out_addr_q <= '0;
			out_status_q <= ST_OK;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_EXEC: begin
					if (go) begin
						if (item.too_large) begin
							out_addr_q <= '0;
							out_status_q <= ST_TOO_LARGE;
						end else if (item.op == OP_FREE) begin
							heads_q[item.cls] <= {1'b0, item.freed} + 1'b1;
							out_addr_q <= '0;
							out_status_q <= ST_OK;
						end else if (head_val != '0) begin
							link_cls_q <= item.cls;
							out_addr_q <= pop_addr;
							out_status_q <= ST_OK;
							state_q <= S_LINK;
						end else if (oom) begin
							out_addr_q <= '0;
							out_status_q <= ST_OOM;
						end else if (need_chunk) begin
							state_q <= S_SPILL;
						end else begin
							ptr_q <= ptr_q + ADDR_W'(blks);
							rem_q <= rem_q - REM_W'(blks);
							out_addr_q <= ptr_q;
							out_status_q <= ST_OK;
						end
					end
				end
				S_LINK: begin
					heads_q[link_cls_q] <= ram_rdata;
					state_q <= S_EXEC;
				end
				S_SPILL: begin
					if (rem_q != '0) begin
						heads_q[head_idx] <= {1'b0, ptr_q} + 1'b1;
					end
					ptr_q <= ADDR_W'(chunks_q) << CHUNK_SHIFT;
					rem_q <= REM_W'(CHUNK_BLOCKS);
					chunks_q <= chunks_q + 1'b1;
					state_q <= S_EXEC;
				end
				default: begin
					state_q <= S_EXEC;
				end
			endcase
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.block_address = out_addr_q;
	assign rsp.status = out_status_q;

	`SCP_ASSERT(a_link_follows_pop, clk, arst_n, state_q == S_LINK |-> $past(ram_re))
	`SCP_ASSERT(a_fail_has_no_addr, clk, arst_n,
		rsp.valid && rsp.status != ST_OK |-> rsp.block_address == '0)
	`SCP_ASSERT_ALWAYS(a_rem_bounded, clk, rem_q <= REM_W'(CHUNK_BLOCKS))
endmodule

@@ hw/rtl/size_class_pool_allocator_unit.sv @@
// A request word waits in the front end queue; its result word is registered in the back end.
// Throughput: one word a cycle while the result channel is ready; a pop from a free list
// holds the back end in S_LINK, as the next list head comes back from the link memory
// as registered read data. A new chunk is opened in S_SPILL before the allocate that needs it.
// Reset: list heads empty and carve state zero at once; the link memory is not cleared.
module size_class_pool_allocator_unit (
	input  logic      clk,
	input  logic      arst_n,
	scp_req_if.sink   req,
	scp_rsp_if.source rsp
);
	import scp_pkg::*;

	q_head_t q_head;
	logic    q_pop;

	scp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.head   (q_head),
		.pop    (q_pop)
	);

	scp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.pop    (q_pop),
		.rsp    (rsp)
	);
endmodule

@@ verif/tb_size_class_pool_allocator_unit.sv @@
// Self-checking testbench of the size class pool allocator: random and directed
// allocate and free words against a built-in prediction of the pools.
// Depends on scp_pkg, scp_req_if, scp_rsp_if and size_class_pool_allocator_unit.
`timescale 1ns / 1ps

module tb_size_class_pool_allocator_unit;
	import scp_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int SHOWN_MISMATCHES = 10;

	typedef struct {
		logic [ADDR_W-1:0] block_address;
		status_t           status;
	} grant_t;

	typedef struct {
		logic [ADDR_W-1:0]  addr;
		logic [BYTES_W-1:0] bytes;
	} held_block_t;

	class alloc_scoreboard;
		logic [LINK_W-1:0] heads[CLASS_COUNT];
		logic [LINK_W-1:0] links[ARENA_BLOCKS];
		int carve_ptr;
		int carve_left;
		int chunks_open;
		grant_t awaited_grants[$];
		int mismatches;

		function new();
			foreach (heads[i])
				heads[i] = '0;
			carve_ptr = 0;
			carve_left = 0;
			chunks_open = 0;
			mismatches = 0;
		endfunction

		function void push_block(int cls, int blk);
			links[blk] = heads[cls];
			heads[cls] = LINK_W'(blk + 1);
		endfunction

		function grant_t predict_grant(op_t op, logic [BYTES_W-1:0] bytes,
				logic [ADDR_W-1:0] freed);
			grant_t g;
			int blks;
			int cls;
			int head;
			g.block_address = '0;
			g.status = ST_OK;
			if (int'(bytes) > MAX_BYTES) begin
				g.status = ST_TOO_LARGE;
				return g;
			end
			blks = (int'(bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
			if (blks == 0)
				blks = 1;
			cls = blks - 1;
			if (op == OP_FREE) begin
				push_block(cls, int'(freed));
			end else if (heads[cls] != '0) begin
				head = int'(heads[cls]);
				g.block_address = ADDR_W'(head - 1);
				heads[cls] = links[head - 1];
			end else if (blks > carve_left && (chunks_open >= CHUNK_COUNT
					|| blks > CHUNK_BLOCKS)) begin
				g.status = ST_OOM;
			end else begin
				// The short remainder of a chunk goes to the list of its own size.
				if (blks > carve_left) begin
					if (carve_left > 0)
						push_block(carve_left - 1, carve_ptr);
					carve_ptr = chunks_open * CHUNK_BLOCKS;
					carve_left = CHUNK_BLOCKS;
					chunks_open++;
				end
				g.block_address = ADDR_W'(carve_ptr);
				carve_ptr += blks;
				carve_left -= blks;
			end
			return g;
		endfunction

		function grant_t record_request(op_t op, logic [BYTES_W-1:0] bytes,
				logic [ADDR_W-1:0] freed);
			grant_t g;
			g = predict_grant(op, bytes, freed);
			awaited_grants.push_back(g);
			return g;
		endfunction

		function void check_grant(logic [ADDR_W-1:0] addr, logic [STATUS_W-1:0] status);
			grant_t g;
			if (awaited_grants.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display("unexpected result word: address %0d status %0d", addr, status);
				return;
			end
			g = awaited_grants.pop_front();
			if (addr !== g.block_address || status !== g.status) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display("mismatch: expected address %0d status %0d, got address %0d status %0d",
						g.block_address, g.status, addr, status);
			end
		endfunction

		function int outstanding();
			return awaited_grants.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	scp_req_if req_ch ();
	scp_rsp_if rsp_ch ();

	size_class_pool_allocator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	alloc_scoreboard board = new();
	held_block_t held_blocks[$];
	int src_idle_pct;
	int snk_idle_pct;
	int oom_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int idle_length(int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_request(op_t op, logic [BYTES_W-1:0] bytes, logic [ADDR_W-1:0] freed);
		int gap;
		grant_t g;
		gap = idle_length(src_idle_pct);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.request_bytes <= bytes;
		req_ch.freed_block <= freed;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		g = board.record_request(op, bytes, freed);
		if (op == OP_ALLOC && g.status == ST_OK)
			held_blocks.push_back('{g.block_address, bytes});
		if (g.status == ST_OOM)
			oom_count++;
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic random_traffic(int count, int alloc_pct, int min_bytes, int oom_stop);
		int r;
		int idx;
		held_block_t blk;
		for (int n = 0; n < count && oom_count < oom_stop; n++) begin
			r = $urandom_range(0, 99);
			if (r < alloc_pct) begin
				send_request(OP_ALLOC, BYTES_W'($urandom_range(min_bytes, MAX_BYTES)),
					ADDR_W'($urandom));
			end else if (r < 92 && held_blocks.size() > 0) begin
				idx = $urandom_range(0, held_blocks.size() - 1);
				blk = held_blocks[idx];
				held_blocks.delete(idx);
				send_request(OP_FREE, blk.bytes, blk.addr);
			end else if (r < 96) begin
				send_request(OP_FREE, BYTES_W'($urandom_range(0, MAX_BYTES)), ADDR_W'($urandom));
			end else begin
				send_request(op_t'($urandom_range(0, 1)),
					BYTES_W'($urandom_range(MAX_BYTES + 1, 65535)), ADDR_W'($urandom));
			end
		end
	endtask

	initial begin : result_sink
		int stall;
		stall = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
				board.check_grant(rsp_ch.block_address, rsp_ch.status);
			if (stall == 0)
				stall = idle_length(snk_idle_pct);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				stall--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
					|| (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin : stimulus
		src_idle_pct = 30;
		snk_idle_pct = 20;
		oom_count = 0;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.operation <= OP_ALLOC;
		req_ch.request_bytes <= '0;
		req_ch.freed_block <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Size extremes, oversized words on both operations, reuse from the lists,
		// a foreign block and a double free.
		send_request(OP_ALLOC, 16'd0, 14'd16383);
		send_request(OP_ALLOC, 16'd1, 14'd0);
		send_request(OP_ALLOC, 16'd32, 14'd0);
		send_request(OP_ALLOC, 16'd33, 14'd0);
		send_request(OP_ALLOC, 16'd512, 14'd0);
		send_request(OP_ALLOC, 16'd513, 14'd0);
		send_request(OP_ALLOC, 16'd65535, 14'd16383);
		send_request(OP_FREE, 16'd513, 14'd16383);
		send_request(OP_FREE, 16'd65535, 14'd0);
		send_request(OP_FREE, 16'd0, 14'd0);
		send_request(OP_ALLOC, 16'd1, 14'd0);
		send_request(OP_FREE, 16'd32, 14'd2);
		send_request(OP_FREE, 16'd20, 14'd1);
		send_request(OP_ALLOC, 16'd0, 14'd0);
		send_request(OP_ALLOC, 16'd16, 14'd0);
		send_request(OP_ALLOC, 16'd16, 14'd0);
		send_request(OP_FREE, 16'd512, 14'd16383);
		send_request(OP_ALLOC, 16'd500, 14'd0);
		send_request(OP_FREE, 16'd64, 14'd3);
		send_request(OP_FREE, 16'd64, 14'd3);
		send_request(OP_ALLOC, 16'd64, 14'd0);
		send_request(OP_ALLOC, 16'd64, 14'd0);
		settle();

		src_idle_pct = 25;
		snk_idle_pct = 15;
		random_traffic(500, 55, 0, 1 << 30);

		src_idle_pct = 0;
		snk_idle_pct = 0;
		random_traffic(400, 85, 449, 1 << 30);
		settle();

		// Large words until the arena is spent and out of memory has been seen often.
		src_idle_pct = 20;
		snk_idle_pct = 25;
		random_traffic(900, 85, 449, 30);

		src_idle_pct = 40;
		snk_idle_pct = 40;
		random_traffic(250, 45, 0, 1 << 30);

		settle();
		repeat (10) @(posedge clk);
		if (board.mismatches == 0 && board.outstanding() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
